// File: rtl/u8sd_pkg.sv
// u8sd_pkg: shared types and constants of the utf-8 stream decoder
// no dependencies; used by u8sd_decode and utf8_stream_decoder_top
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  localparam logic [CpWidth-1:0]  ReplCp  = 21'h00FFFD;
  localparam logic [LenWidth-1:0] LenOne  = 3'd1;

  // results caused by one byte: a run of replacements, then an optional tail item
  typedef struct packed {
    logic [1:0]          rep_cnt;
    logic                tail_valid;
    logic [CpWidth-1:0]  tail_cp;
    logic [LenWidth-1:0] tail_len;
    logic                tail_rep;
  } burst_t;

endpackage

// File: rtl/u8sd_decode.sv
// u8sd_decode: sequence state and per-byte decode into a burst descriptor
// depends on u8sd_pkg
`timescale 1ns / 1ps

module u8sd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output u8sd_pkg::burst_t    burst_o
);

  logic [2:0]                       exp_len_q, exp_len_d;
  logic [1:0]                       taken_q, taken_d;
  logic [u8sd_pkg::CpWidth-1:0]     partial_q, partial_d;
  logic                             is_cont;
  logic [2:0]                       taken_inc;
  logic [u8sd_pkg::CpWidth-1:0]     shifted;

  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign taken_inc = {1'b0, taken_q} + 3'd1;
  assign shifted   = {partial_q[u8sd_pkg::CpWidth-7:0], byte_i[5:0]};

  always_comb begin
    burst_o   = '0;
    exp_len_d = exp_len_q;
    taken_d   = taken_q;
    partial_d = partial_q;
    if (exp_len_q != 3'd0 && is_cont) begin
      if (taken_inc >= exp_len_q) begin
        burst_o.tail_valid = 1'b1;
        burst_o.tail_cp    = shifted;
        burst_o.tail_len   = exp_len_q;
        burst_o.tail_rep   = 1'b0;
        exp_len_d          = 3'd0;
        taken_d            = 2'd0;
        partial_d          = '0;
      end else begin
        taken_d   = taken_inc[1:0];
        partial_d = shifted;
      end
    end else begin
      // open sequence broken or flushed: one replacement per byte taken
      if (exp_len_q != 3'd0) begin
        burst_o.rep_cnt = taken_q;
      end
      exp_len_d = 3'd0;
      taken_d   = 2'd0;
      partial_d = '0;
      if (byte_i != 8'h00) begin
        if (byte_i[7] == 1'b0) begin
          burst_o.tail_valid = 1'b1;
          burst_o.tail_cp    = {{(u8sd_pkg::CpWidth-8){1'b0}}, byte_i};
          burst_o.tail_len   = u8sd_pkg::LenOne;
          burst_o.tail_rep   = 1'b0;
        end else if (byte_i inside {[8'hC0:8'hDF]}) begin
          exp_len_d = 3'd2;
          taken_d   = 2'd1;
          partial_d = {{(u8sd_pkg::CpWidth-5){1'b0}}, byte_i[4:0]};
        end else if (byte_i inside {[8'hE0:8'hEF]}) begin
          exp_len_d = 3'd3;
          taken_d   = 2'd1;
          partial_d = {{(u8sd_pkg::CpWidth-4){1'b0}}, byte_i[3:0]};
        end else if (byte_i inside {[8'hF0:8'hF7]}) begin
          exp_len_d = 3'd4;
          taken_d   = 2'd1;
          partial_d = {{(u8sd_pkg::CpWidth-3){1'b0}}, byte_i[2:0]};
        end else begin
          // stray continuation or 11111xxx
          burst_o.tail_valid = 1'b1;
          burst_o.tail_cp    = u8sd_pkg::ReplCp;
          burst_o.tail_len   = u8sd_pkg::LenOne;
          burst_o.tail_rep   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= 3'd0;
      taken_q   <= 2'd0;
      partial_q <= '0;
    end else if (step_i) begin
      exp_len_q <= exp_len_d;
      taken_q   <= taken_d;
      partial_q <= partial_d;
    end
  end

  a_open_has_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q != 3'd0 |-> taken_q != 2'd0 && {1'b0, taken_q} < exp_len_q)
    else $error("open sequence with bad taken count");

  a_closed_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q == 3'd0 |-> taken_q == 2'd0 && partial_q == '0)
    else $error("closed sequence holds stale state");

endmodule

// File: rtl/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: utf-8 byte stream to code points
// a result passes through the byte register, then the result register; a stalled output holds the byte
// throughput: one byte per cycle while out_ready_i is high and each byte gives at most one item;
// a byte that gives several items holds the single result register until its last item is taken
// reset: asynchronous, clears both valid flags and closes any open sequence
// depends on u8sd_pkg and u8sd_decode
`timescale 1ns / 1ps

module utf8_stream_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          in_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [u8sd_pkg::CpWidth-1:0]        code_point_o,
  output logic [u8sd_pkg::LenWidth-1:0]       source_length_o,
  output logic                                is_replacement_o,
  output logic                                last_of_run_o
);

  logic [7:0]        byte_q;
  logic              byte_valid_q, byte_valid_d;
  u8sd_pkg::burst_t  burst_q, burst_d, dec_burst;
  logic              load;
  logic              out_fire;
  logic              in_fire;

  assign out_valid_o   = (burst_q.rep_cnt != 2'd0) || burst_q.tail_valid;
  assign last_of_run_o = (burst_q.rep_cnt == 2'd0) ||
                         (burst_q.rep_cnt == 2'd1 && !burst_q.tail_valid);
  assign out_fire      = out_valid_o && out_ready_i;
  assign load          = byte_valid_q && (!out_valid_o || (out_ready_i && last_of_run_o));
  assign in_ready_o    = !byte_valid_q || load;
  assign in_fire       = in_valid_i && in_ready_o;

  u8sd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (load),
    .byte_i  (byte_q),
    .burst_o (dec_burst)
  );

  // replacements of a broken sequence go out before the tail item
  assign code_point_o     = (burst_q.rep_cnt != 2'd0) ? u8sd_pkg::ReplCp : burst_q.tail_cp;
  assign source_length_o  = (burst_q.rep_cnt != 2'd0) ? u8sd_pkg::LenOne : burst_q.tail_len;
  assign is_replacement_o = (burst_q.rep_cnt != 2'd0) ? 1'b1 : burst_q.tail_rep;

  always_comb begin
    byte_valid_d = byte_valid_q;
    if (in_fire) begin
      byte_valid_d = 1'b1;
    end else if (load) begin
      byte_valid_d = 1'b0;
    end
  end

  always_comb begin
    burst_d = burst_q;
    if (load) begin
      burst_d = dec_burst;
    end else if (out_fire) begin
      if (burst_q.rep_cnt != 2'd0) begin
        burst_d.rep_cnt = burst_q.rep_cnt - 2'd1;
      end else begin
        burst_d.tail_valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      burst_q      <= '0;
    end else begin
      byte_valid_q <= byte_valid_d;
      burst_q      <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_byte_i;
    end
  end

  a_repl_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_replacement_o |->
      code_point_o == u8sd_pkg::ReplCp && source_length_o == u8sd_pkg::LenOne)
    else $error("replacement item with wrong code point or length");

  a_drain_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_of_run_o && !load |=> !out_valid_o)
    else $error("result register not empty after final item taken");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_valid_o |-> out_ready_i && last_of_run_o)
    else $error("burst loaded over pending items");

  a_stall_holds_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_q && !load |=> byte_valid_q && $stable(byte_q))
    else $error("held byte lost while result stalled");

endmodule
